>>> src/median_3x3_filter_macros.svh
`ifndef MEDIAN_3X3_FILTER_MACROS_SVH
`define MEDIAN_3X3_FILTER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define MF3_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("median_3x3_filter check failed");

// Next-cycle implication, masked while reset is asserted
`define MF3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("median_3x3_filter check failed");

// Next-cycle implication that is also checked during reset
`define MF3_ASSERT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("median_3x3_filter reset check failed");

`endif

>>> src/mf3_pkg.sv
package mf3_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int PIXEL_BITS   = 8;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = 12;
    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 1;
    localparam int WIN          = 3;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    // line store word: {row above, two rows above}
    localparam int LINE_BITS    = 2 * PIXEL_BITS;

    typedef logic [PIXEL_BITS-1:0] t_pixel;
    typedef logic [COL_BITS-1:0]   t_col;
    typedef logic [ROW_BITS-1:0]   t_row;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_pixel hi;
        t_pixel md;
        t_pixel lo;
    } t_trio;

    // position of the pixel being accepted
    typedef struct packed {
        t_col col;
        t_row row;
        logic emit;   // full window completes here
        logic last;   // bottom-right pixel of the frame
    } t_pos;

    function automatic t_trio f_sort3(t_pixel a, t_pixel b, t_pixel c);
        t_pixel x0;
        t_pixel x1;
        t_pixel x2;
        t_pixel t;
        t_trio  r;
        x0 = a;
        x1 = b;
        x2 = c;
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
        end
        if (x1 > x2) begin
            t = x1; x1 = x2; x2 = t;
        end
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
        end
        r.lo = x0;
        r.md = x1;
        r.hi = x2;
        return r;
    endfunction

endpackage

>>> src/mf3_if.sv
interface mf3_pix_if;
    logic            valid;
    logic            ready;
    mf3_pkg::t_pixel pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface mf3_res_if;
    logic            valid;
    logic            ready;
    mf3_pkg::t_pixel median;
    mf3_pkg::t_col   center_col;
    mf3_pkg::t_row   center_row;
    logic            frame_last;

    modport source (output valid, output median, output center_col, output center_row,
                    output frame_last, input ready);
    modport sink   (input valid, input median, input center_col, input center_row,
                    input frame_last, output ready);
endinterface

>>> src/median_3x3_filter.sv
// 3x3 median filter for a raster-order grayscale pixel stream.
//
// i_pix   : pixel request channel (valid/ready), one pixel per request,
//           row by row; after the last pixel of a frame the next one is
//           column 0 of row 0 of a new frame.
// o_res   : result request channel (valid/ready), one result per interior
//           pixel: median of the 3x3 window, center column/row and a flag
//           on the last result of the frame. Border pixels give nothing.
// i_cfg_* : write port; index 0 = image width (3..2048), index 1 = image
//           height (3..4095), saturated on write. Any write restarts the
//           frame at row 0, column 0. Write only while the block is idle.
//
// Throughput: one pixel per clock while o_res.ready keeps results moving.
// Path: a result's bottom-right pixel is accepted with its line store
// read, then column sort, then median select into the output register.
// Reset: pipeline empties, position returns to row 0 column 0, size to
// 640x480. Line store contents are not cleared; they are only read after
// being written in the current frame.
// Stall: each stage holds while the one after it is full, so pixels keep
// being accepted into empty stages while a result waits on o_res.ready.
module median_3x3_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [mf3_pkg::CFG_BITS-1:0]        i_cfg_data,
    mf3_pix_if.sink                             i_pix,
    mf3_res_if.source                           o_res
);

    // stage enables, back to front
    logic en_out;
    logic en_s2;
    logic en_s1;
    logic accept;
    logic s1_adv;

    mf3_pkg::t_pos pos;

    // stage 1: accepted pixel, line store read in flight
    logic            r_s1_valid;
    mf3_pkg::t_pixel r_s1_pixel;
    mf3_pkg::t_pos   r_s1_pos;

    // line store: {row above, two rows above} at each column
    logic [mf3_pkg::LINE_BITS-1:0] line_rd;
    logic [mf3_pkg::LINE_BITS-1:0] line_wr;
    mf3_pkg::t_pixel               mid;
    mf3_pkg::t_pixel               top;

    // window: two previous columns, top/mid/bottom each
    mf3_pkg::t_pixel r_win [6];

    // stage 2: sorted columns of a complete window
    logic            r_s2_valid;
    mf3_pkg::t_trio  r_s2_c0;
    mf3_pkg::t_trio  r_s2_c1;
    mf3_pkg::t_trio  r_s2_c2;
    mf3_pkg::t_col   r_s2_col;
    mf3_pkg::t_row   r_s2_row;
    logic            r_s2_last;

    mf3_pkg::t_pixel median;

    // output register
    logic            r_out_valid;
    mf3_pkg::t_pixel r_out_median;
    mf3_pkg::t_col   r_out_col;
    mf3_pkg::t_row   r_out_row;
    logic            r_out_last;

    assign en_out = !r_out_valid || o_res.ready;
    assign en_s2  = !r_s2_valid || en_out;
    assign en_s1  = !r_s1_valid || en_s2;
    assign accept = i_pix.valid && en_s1;
    assign s1_adv = r_s1_valid && en_s2;

    assign i_pix.ready = en_s1;

    mf3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (mf3_pkg::t_cfg_reg'(i_cfg_idx)),
        .i_cfg_data (i_cfg_data),
        .i_adv      (accept),
        .o_pos      (pos)
    );

    // read at accept; write back when the pixel leaves stage 1.
    // Consecutive pixels hit different columns, so no read/write collision.
    assign mid     = line_rd[mf3_pkg::LINE_BITS-1:mf3_pkg::PIXEL_BITS];
    assign top     = line_rd[mf3_pkg::PIXEL_BITS-1:0];
    assign line_wr = {r_s1_pixel, mid};

    mf3_ram #(
        .WIDTH (mf3_pkg::LINE_BITS),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_pos.col),
        .i_wdata (line_wr),
        .i_re    (accept),
        .i_raddr (pos.col),
        .o_rdata (line_rd)
    );

    mf3_median u_median (
        .i_col0   (r_s2_c0),
        .i_col1   (r_s2_c1),
        .i_col2   (r_s2_c2),
        .o_median (median)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1) begin
                r_s1_valid <= i_pix.valid;
            end
            // only pixels that complete a window go on
            if (en_s2) begin
                r_s2_valid <= r_s1_valid && r_s1_pos.emit;
            end
            if (en_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pix.pixel;
            r_s1_pos   <= pos;
        end
        if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_pixel;
            r_s2_c0   <= mf3_pkg::f_sort3(r_win[0], r_win[1], r_win[2]);
            r_s2_c1   <= mf3_pkg::f_sort3(r_win[3], r_win[4], r_win[5]);
            r_s2_c2   <= mf3_pkg::f_sort3(top, mid, r_s1_pixel);
            r_s2_col  <= r_s1_pos.col - 1'b1;
            r_s2_row  <= r_s1_pos.row - 1'b1;
            r_s2_last <= r_s1_pos.last;
        end
        if (en_out && r_s2_valid) begin
            r_out_median <= median;
            r_out_col    <= r_s2_col;
            r_out_row    <= r_s2_row;
            r_out_last   <= r_s2_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.median     = r_out_median;
    assign o_res.center_col = r_out_col;
    assign o_res.center_row = r_out_row;
    assign o_res.frame_last = r_out_last;

endmodule

>>> src/mf3_ram.sv
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/mf3_ctrl.sv
module mf3_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  mf3_pkg::t_cfg_reg              i_cfg_idx,
    input  logic [mf3_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  logic                           i_adv,
    output mf3_pkg::t_pos                  o_pos
);

    mf3_pkg::t_col r_col;
    mf3_pkg::t_col n_col;
    mf3_pkg::t_row r_row;
    mf3_pkg::t_row n_row;
    mf3_pkg::t_col r_col_last;
    mf3_pkg::t_col n_col_last;
    mf3_pkg::t_row r_row_last;
    mf3_pkg::t_row n_row_last;
    mf3_pkg::t_col width_last;
    mf3_pkg::t_row height_last;

    // saturate the written size and keep it as "last index"
    always_comb begin
        if (i_cfg_data < mf3_pkg::CFG_BITS'(mf3_pkg::WIN)) begin
            width_last = mf3_pkg::COL_BITS'(mf3_pkg::WIN - 1);
        end else if (int'(i_cfg_data) > mf3_pkg::MAX_WIDTH) begin
            width_last = mf3_pkg::COL_BITS'(mf3_pkg::MAX_WIDTH - 1);
        end else begin
            width_last = mf3_pkg::COL_BITS'(i_cfg_data - 1'b1);
        end
        if (i_cfg_data < mf3_pkg::CFG_BITS'(mf3_pkg::WIN)) begin
            height_last = mf3_pkg::ROW_BITS'(mf3_pkg::WIN - 1);
        end else begin
            height_last = mf3_pkg::ROW_BITS'(i_cfg_data - 1'b1);
        end
    end

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_col_last = r_col_last;
        n_row_last = r_row_last;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mf3_pkg::CFG_IMAGE_WIDTH:  n_col_last = width_last;
                mf3_pkg::CFG_IMAGE_HEIGHT: n_row_last = height_last;
            endcase
            // any write restarts the frame
            n_col = '0;
            n_row = '0;
        end else if (i_adv) begin
            if (r_col == r_col_last) begin
                n_col = '0;
                if (r_row == r_row_last) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_col_last <= mf3_pkg::COL_BITS'(mf3_pkg::RESET_WIDTH - 1);
            r_row_last <= mf3_pkg::ROW_BITS'(mf3_pkg::RESET_HEIGHT - 1);
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_col_last <= n_col_last;
            r_row_last <= n_row_last;
        end
    end

    assign o_pos.col  = r_col;
    assign o_pos.row  = r_row;
    assign o_pos.emit = (r_col >= mf3_pkg::COL_BITS'(mf3_pkg::WIN - 1))
                     && (r_row >= mf3_pkg::ROW_BITS'(mf3_pkg::WIN - 1));
    assign o_pos.last = (r_col == r_col_last) && (r_row == r_row_last);

endmodule

>>> src/mf3_median.sv
module mf3_median (
    input  mf3_pkg::t_trio  i_col0,
    input  mf3_pkg::t_trio  i_col1,
    input  mf3_pkg::t_trio  i_col2,
    output mf3_pkg::t_pixel o_median
);

    mf3_pkg::t_trio lows;
    mf3_pkg::t_trio mids;
    mf3_pkg::t_trio highs;
    mf3_pkg::t_trio last3;

    // columns arrive sorted: median9 = med(max of lows, med of mids, min of highs)
    assign lows   = mf3_pkg::f_sort3(i_col0.lo, i_col1.lo, i_col2.lo);
    assign mids   = mf3_pkg::f_sort3(i_col0.md, i_col1.md, i_col2.md);
    assign highs  = mf3_pkg::f_sort3(i_col0.hi, i_col1.hi, i_col2.hi);
    assign last3  = mf3_pkg::f_sort3(lows.hi, mids.md, highs.lo);
    assign o_median = last3.md;

endmodule

>>> src/mf3_checker.sv
`include "median_3x3_filter_macros.svh"

module mf3_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input mf3_pkg::t_pixel i_res_median,
    input mf3_pkg::t_col   i_res_center_col,
    input mf3_pkg::t_row   i_res_center_row,
    input logic            i_res_frame_last
);

    logic [mf3_pkg::PIXEL_BITS+mf3_pkg::COL_BITS+mf3_pkg::ROW_BITS:0] res_payload;
    logic                                                             center_interior;

    assign res_payload     = {i_res_median, i_res_center_col, i_res_center_row,
                              i_res_frame_last};
    assign center_interior = (i_res_center_col != '0) && (i_res_center_row != '0);

    // no result right after reset
    `MF3_ASSERT_RESET(a_rst_no_result, i_clk, !i_rst_n, !i_res_valid)

    // a stalled result stays and holds its payload
    `MF3_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)
    `MF3_ASSERT_NEXT(a_res_stable, i_clk, i_rst_n, i_res_valid && !i_res_ready, $stable(res_payload))

    // interior centers only: never row 0 or column 0
    `MF3_ASSERT_IMPL(a_center_interior, i_clk, i_rst_n, i_res_valid, center_interior)

endmodule

bind median_3x3_filter mf3_checker u_mf3_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_median     (o_res.median),
    .i_res_center_col (o_res.center_col),
    .i_res_center_row (o_res.center_row),
    .i_res_frame_last (o_res.frame_last)
);

>>> sim/median_3x3_filter_checker.sv
module median_3x3_filter_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [mf3_pkg::CFG_BITS-1:0]        i_cfg_data,
    mf3_pix_if                                  pix,
    mf3_res_if                                  res,
    output int                                  o_mismatches,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEIGHT_LIMIT = 4095;

    typedef struct {
        mf3_pkg::t_pixel median;
        mf3_pkg::t_col   col;
        mf3_pkg::t_row   row;
        logic            last;
    } t_window_median;

    t_window_median window_medians_q[$];

    // rows kept for the window: one above and two above the current row
    mf3_pkg::t_pixel row_above     [mf3_pkg::MAX_WIDTH];
    mf3_pkg::t_pixel row_two_above [mf3_pkg::MAX_WIDTH];
    // two previous columns, {top, mid, bottom} each, oldest first
    mf3_pkg::t_pixel prev_cols     [6];
    int unsigned     width_reg;
    int unsigned     height_reg;
    int unsigned     next_col;
    int unsigned     next_row;
    int              mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic mf3_pkg::t_pixel median_of_nine(input mf3_pkg::t_pixel v [9]);
        mf3_pkg::t_pixel s [9];
        mf3_pkg::t_pixel t;
        int              i;
        int              j;
        s = v;
        for (i = 0; i < 8; i++) begin
            for (j = 0; j < 8 - i; j++) begin
                if (s[j] > s[j+1]) begin
                    t = s[j];
                    s[j] = s[j+1];
                    s[j+1] = t;
                end
            end
        end
        return s[4];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: median mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Advance the window by one pixel and queue the median it completes.
    function automatic void predict_pixel(input mf3_pkg::t_pixel p);
        int unsigned     ew;
        int unsigned     eh;
        int unsigned     col;
        int unsigned     row;
        mf3_pkg::t_pixel top;
        mf3_pkg::t_pixel mid;
        mf3_pkg::t_pixel v [9];
        t_window_median  r;
        int              k;
        ew = (width_reg < mf3_pkg::WIN) ? mf3_pkg::WIN
           : ((width_reg > mf3_pkg::MAX_WIDTH) ? mf3_pkg::MAX_WIDTH : width_reg);
        eh = (height_reg < mf3_pkg::WIN) ? mf3_pkg::WIN
           : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
        col = (next_col >= ew) ? 0 : next_col;
        row = (next_row >= eh) ? 0 : next_row;

        top = row_two_above[col];
        mid = row_above[col];
        row_two_above[col] = mid;
        row_above[col] = p;

        if (col >= 2 && row >= 2) begin
            for (k = 0; k < 6; k++) begin
                v[k] = prev_cols[k];
            end
            v[6] = top;
            v[7] = mid;
            v[8] = p;
            r.median = median_of_nine(v);
            r.col    = mf3_pkg::t_col'(col - 1);
            r.row    = mf3_pkg::t_row'(row - 1);
            r.last   = (col == ew - 1) && (row == eh - 1);
            window_medians_q.push_back(r);
        end

        prev_cols[0] = prev_cols[3];
        prev_cols[1] = prev_cols[4];
        prev_cols[2] = prev_cols[5];
        prev_cols[3] = top;
        prev_cols[4] = mid;
        prev_cols[5] = p;

        col++;
        if (col >= ew) begin
            col = 0;
            row++;
            if (row >= eh) begin
                row = 0;
            end
        end
        next_col = col;
        next_row = row;
    endfunction

    always @(posedge i_clk) begin : watch
        t_window_median exp_m;
        int             i;
        if (!i_rst_n) begin
            for (i = 0; i < mf3_pkg::MAX_WIDTH; i++) begin
                row_above[i] = '0;
                row_two_above[i] = '0;
            end
            for (i = 0; i < 6; i++) begin
                prev_cols[i] = '0;
            end
            width_reg  = mf3_pkg::RESET_WIDTH;
            height_reg = mf3_pkg::RESET_HEIGHT;
            next_col   = 0;
            next_row   = 0;
            window_medians_q.delete();
        end else begin
            // results first: a pixel taken at this edge cannot have a result yet
            if (res.valid && res.ready) begin
                if (window_medians_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result median=%0d col=%0d row=%0d",
                                              res.median, res.center_col, res.center_row));
                end else begin
                    exp_m = window_medians_q.pop_front();
                    if (res.median !== exp_m.median)
                        report_mismatch($sformatf("median %0d, expected %0d (col %0d row %0d)",
                                                  res.median, exp_m.median,
                                                  exp_m.col, exp_m.row));
                    if (res.center_col !== exp_m.col)
                        report_mismatch($sformatf("center_col %0d, expected %0d",
                                                  res.center_col, exp_m.col));
                    if (res.center_row !== exp_m.row)
                        report_mismatch($sformatf("center_row %0d, expected %0d",
                                                  res.center_row, exp_m.row));
                    if (res.frame_last !== exp_m.last)
                        report_mismatch($sformatf("frame_last %0b, expected %0b (col %0d row %0d)",
                                                  res.frame_last, exp_m.last,
                                                  exp_m.col, exp_m.row));
                end
            end
            if (i_cfg_we) begin
                case (mf3_pkg::t_cfg_reg'(i_cfg_idx))
                    mf3_pkg::CFG_IMAGE_WIDTH:  width_reg  = i_cfg_data;
                    mf3_pkg::CFG_IMAGE_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
                next_col = 0;
                next_row = 0;
            end
            if (pix.valid && pix.ready) begin
                predict_pixel(pix.pixel);
            end
        end
        o_pending <= window_medians_q.size();
    end

endmodule

>>> sim/median_3x3_filter_tb.sv
module median_3x3_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Settle time after the drain covers border pixels still in flight
    // before a register write.
    localparam int SETTLE_CYCLES = 8;
    // Long receiver hold-off so the line/window stages fill and stall input.
    localparam int HOLD_CYCLES   = 64;
    // Cycles without any request accepted before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 600;
    // width of the frame that carries the fixed pattern
    localparam int PATTERN_WIDTH = 25;

    // two 3x3 frames: distinct descending values, then heavy ties
    localparam mf3_pkg::t_pixel TINY_FRAMES [18] = '{
        8'd255, 8'd227, 8'd199, 8'd171, 8'd143, 8'd115, 8'd87, 8'd59, 8'd0,
        8'd7,   8'd7,   8'd200, 8'd3,   8'd7,   8'd3,   8'd200, 8'd3, 8'd7
    };

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [mf3_pkg::CFG_IDX_BITS-1:0]   cfg_idx;
    logic [mf3_pkg::CFG_BITS-1:0]       cfg_data;

    int                    mismatch_count;
    int                    pending_results;

    // idle control for the sender and the receiver process, set by the stimulus
    bit                    src_idle;
    bit                    sink_idle;
    bit                    sink_hold;

    mf3_pix_if pix_if ();
    mf3_res_if res_if ();

    median_3x3_filter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    median_3x3_filter_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .pix          (pix_if),
        .res          (res_if),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_results)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly uniform pixels, with a share of 0/255 to force ties and extremes.
    function automatic mf3_pkg::t_pixel random_pixel();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return mf3_pkg::t_pixel'($urandom_range(0, 255));
    endfunction

    // One pixel request. Valid is left high on return; the next call or a
    // drain sets it in the same time step, so it never toggles within a step.
    task automatic send_pixel(input mf3_pkg::t_pixel p);
        int gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= p;
        do @(posedge clk); while (!pix_if.ready);
    endtask

    // Stop offering pixels until every predicted median has come out,
    // then let the pipeline settle.
    task automatic drain_results();
        pix_if.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both writes restart the frame; only done with the block drained.
    task automatic set_frame(input logic [mf3_pkg::CFG_BITS-1:0] w,
                             input logic [mf3_pkg::CFG_BITS-1:0] h);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= mf3_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx  <= mf3_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Random pixels, re-drawing the idle pattern of both sides every 128.
    task automatic stream_random(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            if (i % 128 == 0) begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            send_pixel(random_pixel());
        end
    endtask

    // Result receiver: random ready gaps, plus one long hold-off on request.
    initial begin : result_sink
        int gap;
        res_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (sink_hold) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
            end
            gap = sink_idle ? $urandom_range(0, 5) : 0;
            if (gap != 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
        end
    end

    // Hang detector: any accepted request on either channel resets the count.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [mf3_pkg::CFG_BITS-1:0] w;
        logic [mf3_pkg::CFG_BITS-1:0] h;
        int                           ew;
        int                           eh;
        int                           n;
        int                           rand_count;
        int                           row;
        int                           col;
        int                           i;

        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= mf3_pkg::CFG_IMAGE_WIDTH;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        sink_hold    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size (640 wide): the start of row 0 gives no result.
        stream_random(30);

        // Three rows of a narrow frame with a fixed pattern: all-zero
        // windows, all-255 windows, then walking ones (inverted on the
        // middle row).
        set_frame(mf3_pkg::CFG_BITS'(PATTERN_WIDTH), 12'd3);
        for (row = 0; row < 3; row++) begin
            for (col = 0; col < PATTERN_WIDTH; col++) begin
                if (col < 8)
                    send_pixel(8'h00);
                else if (col < 16)
                    send_pixel(8'hFF);
                else
                    send_pixel(mf3_pkg::t_pixel'(9'd1 << (col - 16))
                               ^ ((row == 1) ? 8'hFF : 8'h00));
            end
        end

        // Undersized registers saturate to 3x3; two back-to-back frames
        // exercise frame_last and the wrap to row 0.
        set_frame(12'd0, 12'd0);
        for (i = 0; i < 18; i++) begin
            send_pixel(TINY_FRAMES[i]);
        end
        set_frame(12'd2, 12'd1);
        stream_random(9);
        set_frame(12'd3, 12'd3);
        stream_random(9);

        // Oversized width saturates to the line store depth, abandoned early.
        set_frame(12'hFFF, 12'd3);
        stream_random(20);
        // exact maximum width with tallest height, abandoned early
        set_frame(12'd2048, 12'd4095);
        stream_random(20);
        // tallest frame, narrowest width, cut short after 40 rows
        set_frame(12'd3, 12'd4095);
        stream_random(3 * 40);

        // Receiver holds off while pixels keep coming back to back; later
        // the sender stops mid-frame until every result is out.
        set_frame(12'd5, 12'd5);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 1'b1;
        for (i = 0; i < 40; i++) begin
            send_pixel(random_pixel());
        end
        drain_results();
        stream_random(35);

        // Random frame sizes, mostly small, some saturating or very tall.
        rand_count = 0;
        while (rand_count < RANDOM_ITEMS) begin
            w = mf3_pkg::CFG_BITS'($urandom_range(3, 16));
            h = mf3_pkg::CFG_BITS'($urandom_range(3, 10));
            case ($urandom_range(0, 7))
                0: w = mf3_pkg::CFG_BITS'($urandom_range(0, 2));
                1: h = mf3_pkg::CFG_BITS'($urandom_range(0, 2));
                2: h = mf3_pkg::CFG_BITS'($urandom_range(11, 4095));
                default: ;
            endcase
            ew = (w < mf3_pkg::WIN) ? mf3_pkg::WIN : w;
            eh = (h < mf3_pkg::WIN) ? mf3_pkg::WIN : ((h > 10) ? 10 : h);
            n  = $urandom_range(3 * ew, 2 * ew * eh + ew);
            set_frame(w, h);
            stream_random(n);
            rand_count += n;
        end

        drain_results();
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
